[rtl/whcbg_pkg.sv]
package whcbg_pkg;

	localparam int NUM_CACHES = 8;
	localparam int IDX_W = (NUM_CACHES > 1) ? $clog2(NUM_CACHES) : 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [2:0] TTL_FULL = 3'd4;
	localparam logic [2:0] TTL_HALF = 3'd2;
	localparam logic [2:0] TTL_QUARTER = 3'd1;
	localparam logic [2:0] TTL_NONE = 3'd0;

	localparam logic [15:0] RST_WIN_LEN = 16'd1000;
	localparam logic [15:0] RST_HOT_THRESHOLD = 16'd16;
	localparam logic [7:0] RST_PRESSURE_TYPE = 8'd2;

	typedef enum logic [2:0] {
		REQ_BUMP   = 3'd0,
		REQ_BYPASS = 3'd1,
		REQ_TTL    = 3'd2,
		REQ_FRAME  = 3'd3,
		REQ_STATS  = 3'd4
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE        = 2'd0,
		CFG_WIN_LEN       = 2'd1,
		CFG_HOT_THRESHOLD = 2'd2,
		CFG_PRESSURE_TYPE = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_BUMP,
		OP_BYPASS,
		OP_TTL,
		OP_FRAME,
		OP_STATS
	} op_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [3:0]  cache_id;
		logic [31:0] now_ms;
		logic [7:0]  sampled_type;
		logic        type_readable;
	} in_item_t;

	typedef struct packed {
		logic        id_valid;
		logic        bypass;
		logic [2:0]  ttl_quarters;
		logic        window_rolled;
		logic        pressure_mode;
		logic [7:0]  last_type;
		logic [31:0] window_count;
		logic [31:0] bypass_count;
		logic [63:0] total_bump_count;
		logic [63:0] total_bypass_count;
		logic        is_active;
	} out_item_t;

	typedef struct packed {
		op_t              op;
		logic             id_valid;
		logic [IDX_W-1:0] idx;
		logic [31:0]      now_ms;
		logic [7:0]       sampled_type;
		logic             type_readable;
	} entry_t;

	typedef struct packed {
		logic        enable;
		logic [15:0] win_len;
		logic [15:0] hot_threshold;
		logic [7:0]  pressure_type;
	} cfg_t;

endpackage

[rtl/whcbg_front.sv]
module whcbg_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  whcbg_pkg::in_item_t in_item,
	output logic                push_valid,
	input  logic                push_ready,
	output whcbg_pkg::entry_t   push_entry
);
	import whcbg_pkg::*;

	logic   vld_s1;
	entry_t entry_s1;
	entry_t entry_d;

	always_comb begin
		entry_d.id_valid = {1'b0, in_item.cache_id} < 5'(NUM_CACHES);
		entry_d.idx = in_item.cache_id[IDX_W-1:0];
		entry_d.now_ms = in_item.now_ms;
		entry_d.sampled_type = in_item.sampled_type;
		entry_d.type_readable = in_item.type_readable;
		unique case (in_item.req_type)
			REQ_BUMP:   entry_d.op = OP_BUMP;
			REQ_BYPASS: entry_d.op = OP_BYPASS;
			REQ_TTL:    entry_d.op = OP_TTL;
			REQ_FRAME:  entry_d.op = OP_FRAME;
			REQ_STATS:  entry_d.op = OP_STATS;
			default:    entry_d.op = OP_NONE;
		endcase
	end

	assign in_ready = !vld_s1 || push_ready;
	assign push_valid = vld_s1;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

[rtl/whcbg_queue.sv]
module whcbg_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  whcbg_pkg::entry_t push_entry,
	output logic              pop_valid,
	input  logic              pop_ready,
	output whcbg_pkg::entry_t pop_entry
);
	import whcbg_pkg::*;

	entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_entry = slot_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

[rtl/whcbg_back.sv]
module whcbg_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  whcbg_pkg::cfg_t      cfg,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  whcbg_pkg::entry_t    pop_entry,
	output logic                 out_valid,
	input  logic                 out_ready,
	output whcbg_pkg::out_item_t out_item
);
	import whcbg_pkg::*;

	logic [31:0] accum_q [NUM_CACHES];
	logic [31:0] wcnt_q [NUM_CACHES];
	logic [31:0] byp_q [NUM_CACHES];
	logic [31:0] wstart_q;
	logic        pflag_q;
	logic [7:0]  stype_q;
	logic [63:0] bump_total_q;
	logic [63:0] byp_total_q;
	logic        out_vld_q;
	out_item_t   out_item_q;

	logic        fire;
	logic        use_id;
	logic [31:0] wcnt;
	logic        hot;
	logic [31:0] diff;
	logic        roll;
	logic        bump_hit;
	logic        byp_hit;
	logic        pflag_d;
	logic [7:0]  stype_d;
	out_item_t   rsp_d;

	assign pop_ready = !out_vld_q || out_ready;
	assign fire = pop_valid && pop_ready;
	assign out_valid = out_vld_q;
	assign out_item = out_item_q;

	always_comb begin
		use_id = cfg.enable && pop_entry.id_valid;
		wcnt = wcnt_q[pop_entry.idx];
		hot = wcnt >= {16'd0, cfg.hot_threshold};
		diff = pop_entry.now_ms - wstart_q;
		roll = (pop_entry.op == OP_FRAME) && cfg.enable && !diff[31]
			&& (diff >= {16'd0, cfg.win_len});
		bump_hit = (pop_entry.op == OP_BUMP) && use_id;
		byp_hit = (pop_entry.op == OP_BYPASS) && use_id && ((pflag_q && wcnt != '0) || hot);
		pflag_d = roll ? (pop_entry.type_readable && pop_entry.sampled_type == cfg.pressure_type)
			: pflag_q;
		stype_d = roll ? (pop_entry.type_readable ? pop_entry.sampled_type : 8'd0) : stype_q;

		rsp_d = '0;
		rsp_d.id_valid = pop_entry.id_valid;
		rsp_d.bypass = byp_hit;
		rsp_d.window_rolled = roll;
		rsp_d.pressure_mode = pflag_d;
		rsp_d.last_type = stype_d;
		rsp_d.is_active = cfg.enable;
		if (pop_entry.op == OP_TTL) begin
			if (!use_id) begin
				rsp_d.ttl_quarters = TTL_FULL;
			end else if (pflag_q && hot) begin
				rsp_d.ttl_quarters = TTL_NONE;
			end else if (pflag_q) begin
				rsp_d.ttl_quarters = TTL_QUARTER;
			end else if (hot) begin
				rsp_d.ttl_quarters = TTL_HALF;
			end else begin
				rsp_d.ttl_quarters = TTL_FULL;
			end
		end
		if (pop_entry.op == OP_STATS) begin
			if (pop_entry.id_valid) begin
				rsp_d.window_count = wcnt;
				rsp_d.bypass_count = byp_q[pop_entry.idx];
			end
			rsp_d.total_bump_count = bump_total_q;
			rsp_d.total_bypass_count = byp_total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CACHES; i++) begin
				accum_q[i] <= '0;
				wcnt_q[i] <= '0;
				byp_q[i] <= '0;
			end
			wstart_q <= '0;
			pflag_q <= 1'b0;
			stype_q <= '0;
			bump_total_q <= '0;
			byp_total_q <= '0;
		end else if (fire) begin
			if (bump_hit) begin
				if (accum_q[pop_entry.idx] != '1) begin
					accum_q[pop_entry.idx] <= accum_q[pop_entry.idx] + 32'd1;
				end
				bump_total_q <= bump_total_q + 64'd1;
			end
			if (byp_hit) begin
				byp_q[pop_entry.idx] <= byp_q[pop_entry.idx] + 32'd1;
				byp_total_q <= byp_total_q + 64'd1;
			end
			if (roll) begin
				for (int i = 0; i < NUM_CACHES; i++) begin
					wcnt_q[i] <= accum_q[i];
					accum_q[i] <= '0;
				end
				wstart_q <= pop_entry.now_ms;
			end
			pflag_q <= pflag_d;
			stype_q <= stype_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_item_q <= rsp_d;
		end
	end

endmodule

[rtl/windowed_hot_cache_bypass_governor_unit.sv]
// channel   handshake               payload
// in        in_valid / in_ready     in_item  (whcbg_pkg::in_item_t)
// out       out_valid / out_ready   out_item (whcbg_pkg::out_item_t)
// cfg       cfg_we                  cfg_index, cfg_wdata
//
// one item per cycle sustained while out_ready stays high; each item passes in order through the
// front classify register, the two-entry queue and the back execute stage with output register
// per-cache counters, window state and totals live in the back stage
// reset clears all counters, window start, pressure state; config takes its defaults
// an output stall fills the queue, then holds in_ready low
module windowed_hot_cache_bypass_governor_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  whcbg_pkg::in_item_t                   in_item,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output whcbg_pkg::out_item_t                  out_item,
	input  logic                                  cfg_we,
	input  logic [whcbg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [whcbg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import whcbg_pkg::*;

	cfg_t   cfg_q;
	logic   push_valid;
	logic   push_ready;
	entry_t push_entry;
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b1;
			cfg_q.win_len <= RST_WIN_LEN;
			cfg_q.hot_threshold <= RST_HOT_THRESHOLD;
			cfg_q.pressure_type <= RST_PRESSURE_TYPE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE:        cfg_q.enable <= cfg_wdata[0];
				CFG_WIN_LEN:       cfg_q.win_len <= cfg_wdata;
				CFG_HOT_THRESHOLD: cfg_q.hot_threshold <= cfg_wdata;
				CFG_PRESSURE_TYPE: cfg_q.pressure_type <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	whcbg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	whcbg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	whcbg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// only one kind of answer per result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.bypass |->
			out_item.ttl_quarters == TTL_NONE && !out_item.window_rolled
			&& out_item.id_valid && out_item.is_active)
		else $error("bypass result carries other answers");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.ttl_quarters == TTL_NONE || out_item.ttl_quarters == TTL_QUARTER
			|| out_item.ttl_quarters == TTL_HALF || out_item.ttl_quarters == TTL_FULL)
		else $error("illegal ttl code");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.window_rolled |-> out_item.is_active)
		else $error("window closed while disabled");

	// queue full with a stage waiting must hold off new transfers
	assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && !push_ready |-> !in_ready)
		else $error("front accepted while blocked");

endmodule

[dv/tb_windowed_hot_cache_bypass_governor_unit.sv]
`timescale 1ns / 1ps
module tb_windowed_hot_cache_bypass_governor_unit;
	import whcbg_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 680;
	localparam int SETTING_COUNT = 8;
	localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
	localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_item;
	logic out_valid;
	logic out_ready;
	out_item_t out_item;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// governor shadow state
	logic gov_enable;
	logic [15:0] gov_window;
	logic [15:0] gov_hot;
	logic [7:0] gov_ptype;
	logic [31:0] acc_bumps [NUM_CACHES];
	logic [31:0] last_counts [NUM_CACHES];
	logic [31:0] bypass_issued [NUM_CACHES];
	logic [31:0] win_start;
	logic press_on;
	logic [7:0] kept_type;
	logic [63:0] bumps_all;
	logic [63:0] bypasses_all;

	out_item_t pending_answers [$];
	stim_row_t directed_rows [$];
	int n_errors = 0;
	int n_in = 0;
	int n_out = 0;
	int n_rolls = 0;
	int n_bypass = 0;
	int n_settings = 0;
	int quiet = 0;
	bit no_idle = 1'b0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	windowed_hot_cache_bypass_governor_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	function automatic out_item_t govern_step(in_item_t it);
		out_item_t r;
		logic [IDX_W-1:0] k;
		logic ok;
		logic hot;
		logic [31:0] diff;
		int i;
		ok = it.cache_id < NUM_CACHES;
		k = it.cache_id[IDX_W-1:0];
		hot = ok && (last_counts[k] >= {16'd0, gov_hot});
		r = '0;
		r.id_valid = ok;
		case (it.req_type)
			REQ_BUMP: begin
				if (gov_enable && ok) begin
					if (acc_bumps[k] != 32'hFFFF_FFFF)
						acc_bumps[k] = acc_bumps[k] + 1;
					bumps_all = bumps_all + 1;
				end
			end
			REQ_BYPASS: begin
				if (gov_enable && ok && ((press_on && last_counts[k] != 0) || hot)) begin
					bypass_issued[k] = bypass_issued[k] + 1;
					bypasses_all = bypasses_all + 1;
					r.bypass = 1'b1;
				end
			end
			REQ_TTL: begin
				r.ttl_quarters = TTL_FULL;
				if (gov_enable && ok) begin
					if (press_on && hot)
						r.ttl_quarters = TTL_NONE;
					else if (press_on)
						r.ttl_quarters = TTL_QUARTER;
					else if (hot)
						r.ttl_quarters = TTL_HALF;
				end
			end
			REQ_FRAME: begin
				diff = it.now_ms - win_start;
				if (gov_enable && !diff[31] && diff >= {16'd0, gov_window}) begin
					for (i = 0; i < NUM_CACHES; i++) begin
						last_counts[i] = acc_bumps[i];
						acc_bumps[i] = '0;
					end
					win_start = it.now_ms;
					kept_type = it.type_readable ? it.sampled_type : 8'd0;
					press_on = it.type_readable && (it.sampled_type == gov_ptype);
					r.window_rolled = 1'b1;
				end
			end
			REQ_STATS: begin
				if (ok) begin
					r.window_count = last_counts[k];
					r.bypass_count = bypass_issued[k];
				end
				r.total_bump_count = bumps_all;
				r.total_bypass_count = bypasses_all;
			end
			default: ;
		endcase
		r.pressure_mode = press_on;
		r.last_type = kept_type;
		r.is_active = gov_enable;
		return r;
	endfunction

	function automatic in_item_t mk_in(logic [2:0] req, logic [3:0] id, logic [31:0] now,
		logic [7:0] samp, logic rd);
		in_item_t it;
		it.req_type = req;
		it.cache_id = id;
		it.now_ms = now;
		it.sampled_type = samp;
		it.type_readable = rd;
		return it;
	endfunction

	// plain answers with empty counters and the block enabled
	function automatic out_item_t mk_out(logic idv, logic [2:0] ttl, logic rolled, logic press,
		logic [7:0] lt);
		out_item_t r;
		r = '0;
		r.id_valid = idv;
		r.ttl_quarters = ttl;
		r.window_rolled = rolled;
		r.pressure_mode = press;
		r.last_type = lt;
		r.is_active = 1'b1;
		return r;
	endfunction

	task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
		n_errors++;
		$display("[%0t] mismatch %s: got 0x%0h want 0x%0h (%0d so far)", $time, what, got, want,
			n_errors);
	endtask

	task automatic compare_answer(out_item_t got, out_item_t want);
		if (got.id_valid !== want.id_valid)
			note_mismatch("id_valid", got.id_valid, want.id_valid);
		if (got.bypass !== want.bypass)
			note_mismatch("bypass", got.bypass, want.bypass);
		if (got.ttl_quarters !== want.ttl_quarters)
			note_mismatch("ttl_quarters", got.ttl_quarters, want.ttl_quarters);
		if (got.window_rolled !== want.window_rolled)
			note_mismatch("window_rolled", got.window_rolled, want.window_rolled);
		if (got.pressure_mode !== want.pressure_mode)
			note_mismatch("pressure_mode", got.pressure_mode, want.pressure_mode);
		if (got.last_type !== want.last_type)
			note_mismatch("last_type", got.last_type, want.last_type);
		if (got.window_count !== want.window_count)
			note_mismatch("window_count", got.window_count, want.window_count);
		if (got.bypass_count !== want.bypass_count)
			note_mismatch("bypass_count", got.bypass_count, want.bypass_count);
		if (got.total_bump_count !== want.total_bump_count)
			note_mismatch("total_bump_count", got.total_bump_count, want.total_bump_count);
		if (got.total_bypass_count !== want.total_bypass_count)
			note_mismatch("total_bypass_count", got.total_bypass_count, want.total_bypass_count);
		if (got.is_active !== want.is_active)
			note_mismatch("is_active", got.is_active, want.is_active);
	endtask

	task automatic feed(in_item_t it, bit typed, out_item_t want);
		int gap;
		out_item_t p;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		p = govern_step(it);
		pending_answers.push_back(typed ? want : p);
		n_in++;
		n_rolls += p.window_rolled;
		n_bypass += p.bypass;
	endtask

	// sender holds off until every answer is back
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CFG_ENABLE: gov_enable = val[0];
			CFG_WIN_LEN: gov_window = val;
			CFG_HOT_THRESHOLD: gov_hot = val;
			CFG_PRESSURE_TYPE: gov_ptype = val[7:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(logic [15:0] en, logic [15:0] win, logic [15:0] hot,
		logic [15:0] pt);
		write_reg(CFG_ENABLE, en);
		write_reg(CFG_WIN_LEN, win);
		write_reg(CFG_HOT_THRESHOLD, hot);
		write_reg(CFG_PRESSURE_TYPE, pt);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0)
				note_mismatch("result with nothing pending", out_item.id_valid, 64'd0);
			else
				compare_answer(out_item, pending_answers.pop_front());
			n_out++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d answers pending", quiet,
				pending_answers.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int ph;
		int n;
		int pick;
		int i;
		in_item_t it;
		in_valid <= 1'b0;
		in_item <= '0;
		out_ready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ENABLE;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		gov_enable = 1'b1;
		gov_window = RST_WIN_LEN;
		gov_hot = RST_HOT_THRESHOLD;
		gov_ptype = RST_PRESSURE_TYPE;
		for (i = 0; i < NUM_CACHES; i++) begin
			acc_bumps[i] = '0;
			last_counts[i] = '0;
			bypass_issued[i] = '0;
		end
		win_start = '0;
		press_on = 1'b0;
		kept_type = '0;
		bumps_all = '0;
		bypasses_all = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// low hot threshold so a couple of bumps make an id hot
		program_regs(16'd1, RST_WIN_LEN, 16'd2, RST_PRESSURE_TYPE);

		directed_rows.push_back('{mk_in(REQ_STATS, 4'd0, 32'd0, 8'd0, 1'b0), 1'b1,
			mk_out(1'b1, TTL_NONE, 1'b0, 1'b0, 8'd0)});
		directed_rows.push_back('{mk_in(REQ_STATS, 4'd15, 32'd0, 8'd0, 1'b0), 1'b1,
			mk_out(1'b0, TTL_NONE, 1'b0, 1'b0, 8'd0)});
		directed_rows.push_back('{mk_in(REQ_TTL, 4'd0, 32'd0, 8'd0, 1'b0), 1'b1,
			mk_out(1'b1, TTL_FULL, 1'b0, 1'b0, 8'd0)});
		directed_rows.push_back('{mk_in(REQ_BYPASS, 4'd0, 32'd0, 8'd0, 1'b0), 1'b1,
			mk_out(1'b1, TTL_NONE, 1'b0, 1'b0, 8'd0)});
		directed_rows.push_back('{mk_in(REQ_BUMP, 4'd0, 32'd0, 8'd0, 1'b0), 1'b0, '0});
		directed_rows.push_back('{mk_in(REQ_BUMP, 4'd0, 32'd0, 8'd0, 1'b0), 1'b0, '0});
		directed_rows.push_back('{mk_in(REQ_BUMP, 4'd9, 32'd0, 8'd0, 1'b0), 1'b1,
			mk_out(1'b0, TTL_NONE, 1'b0, 1'b0, 8'd0)});
		directed_rows.push_back('{mk_in(REQ_BUMP, 4'd7, 32'd0, 8'd0, 1'b0), 1'b0, '0});
		// one ms short of the window
		directed_rows.push_back('{mk_in(REQ_FRAME, 4'd0, 32'd999, 8'd2, 1'b1), 1'b1,
			mk_out(1'b1, TTL_NONE, 1'b0, 1'b0, 8'd0)});
		directed_rows.push_back('{mk_in(REQ_FRAME, 4'd15, 32'd1000, 8'd2, 1'b1), 1'b0, '0});
		directed_rows.push_back('{mk_in(REQ_TTL, 4'd0, 32'd0, 8'd0, 1'b0), 1'b0, '0});
		directed_rows.push_back('{mk_in(REQ_BYPASS, 4'd0, 32'd0, 8'd0, 1'b0), 1'b0, '0});
		directed_rows.push_back('{mk_in(REQ_BYPASS, 4'd7, 32'd0, 8'd0, 1'b0), 1'b0, '0});
		directed_rows.push_back('{mk_in(REQ_BYPASS, 4'd3, 32'd0, 8'd0, 1'b0), 1'b0, '0});
		directed_rows.push_back('{mk_in(REQ_TTL, 4'd3, 32'd0, 8'd0, 1'b0), 1'b0, '0});
		directed_rows.push_back('{mk_in(REQ_TTL, 4'd12, 32'd0, 8'd0, 1'b0), 1'b1,
			mk_out(1'b0, TTL_FULL, 1'b0, 1'b1, 8'd2)});
		// negative distance never closes a window
		directed_rows.push_back('{mk_in(REQ_FRAME, 4'd0, 32'd0, 8'd0, 1'b1), 1'b0, '0});
		directed_rows.push_back('{mk_in(REQ_BUMP, 4'd0, 32'd0, 8'd0, 1'b0), 1'b0, '0});
		directed_rows.push_back('{mk_in(REQ_BUMP, 4'd0, 32'd0, 8'd0, 1'b0), 1'b0, '0});
		// unreadable sample clears the type and pressure
		directed_rows.push_back('{mk_in(REQ_FRAME, 4'd0, 32'd2000, 8'hFF, 1'b0), 1'b0, '0});
		directed_rows.push_back('{mk_in(REQ_TTL, 4'd0, 32'd0, 8'd0, 1'b0), 1'b0, '0});
		directed_rows.push_back('{mk_in(REQ_FRAME, 4'd0, 32'h8000_07CF, 8'h80, 1'b1), 1'b0,
			'0});
		directed_rows.push_back('{mk_in(REQ_FRAME, 4'd0, 32'hFFFF_FFFF, 8'h7F, 1'b1), 1'b0,
			'0});
		// timestamp wraps through zero
		directed_rows.push_back('{mk_in(REQ_FRAME, 4'd0, 32'h0000_03E7, 8'd2, 1'b1), 1'b0,
			'0});
		directed_rows.push_back('{mk_in(REQ_STATS, 4'd0, 32'd0, 8'd0, 1'b0), 1'b0, '0});
		directed_rows.push_back('{mk_in(REQ_UNUSED_LO, 4'd0, 32'd0, 8'd0, 1'b0), 1'b0, '0});
		directed_rows.push_back('{mk_in(REQ_UNUSED_HI, 4'd15, 32'd0, 8'd0, 1'b0), 1'b0, '0});

		foreach (directed_rows[i])
			feed(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

		for (ph = 0; ph < SETTING_COUNT; ph++) begin
			settle();
			case (ph)
				0: program_regs(16'd1, 16'd1, 16'd1, 16'd0);
				1: program_regs(16'd1, 16'd65535, 16'd65535, 16'd255);
				2: program_regs(16'd0, 16'($urandom_range(1, 64)), 16'($urandom_range(1, 4)),
					16'($urandom_range(0, 3)));
				3: program_regs(16'd1, 16'd0, 16'd0, 16'($urandom_range(0, 255)));
				default: program_regs(16'($urandom_range(0, 5) != 0),
					16'($urandom_range(1, 64)), 16'($urandom_range(1, 4)),
					16'($urandom_range(0, 3)));
			endcase
			no_idle = (ph % 3 == 1);
			for (n = 0; n < RANDOM_ITEMS / SETTING_COUNT; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 35)
					it.req_type = REQ_BUMP;
				else if (pick < 55)
					it.req_type = REQ_BYPASS;
				else if (pick < 70)
					it.req_type = REQ_TTL;
				else if (pick < 85)
					it.req_type = REQ_FRAME;
				else
					it.req_type = REQ_STATS;
				if ($urandom_range(0, 9) == 0)
					it.cache_id = 4'($urandom_range(NUM_CACHES, 15));
				else
					it.cache_id = 4'($urandom_range(0, NUM_CACHES - 1));
				if ($urandom_range(0, 7) == 0)
					it.now_ms = $urandom();
				else
					it.now_ms = win_start + $urandom_range(0, 2 * int'(gov_window) + 1);
				it.sampled_type = $urandom_range(0, 1) ? gov_ptype : 8'($urandom());
				it.type_readable = $urandom_range(0, 4) != 0;
				feed(it, 1'b0, '0);
			end
		end
		settle();

		$display("covered %0d transfers in, %0d results checked, over %0d register settings",
			n_in, n_out, n_settings);
		$display("windows closed: %0d, bypasses granted: %0d", n_rolls, n_bypass);
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[windowed_hot_cache_bypass_governor_unit.f]
rtl/whcbg_pkg.sv
rtl/whcbg_front.sv
rtl/whcbg_queue.sv
rtl/whcbg_back.sv
rtl/windowed_hot_cache_bypass_governor_unit.sv
dv/tb_windowed_hot_cache_bypass_governor_unit.sv
